### hdl/sliding_window_max_unit_defines.svh
// ----------------------------------------------------------------------------
// Sliding window maximum: assertion macros
// Shared property forms for the checker, sampled on i_clk with reset off.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAX_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_MAX_UNIT_DEFINES_SVH

// same-cycle implication
`define SWM_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/swm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window maximum: package
// Transaction types, cell types and sizing constants.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int WIN_W          = 7;
    localparam int MAX_WINDOW_DEF = 64;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       end_of_sequence;
    } t_swm_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] window_max;
        logic                       last_of_sequence;
    } t_swm_out;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] value;
    } t_cand;

    typedef struct packed {
        logic step;
        logic clear;
        logic drop;
    } t_cell_ctl;

endpackage

### hdl/sliding_window_max_unit.sv
// ----------------------------------------------------------------------------
// Sliding window maximum unit
// Reports the largest of the last window_size (clamped 1..MAX_WINDOW) signed
// samples of a sequence, one result per sample once that many have arrived.
// Candidates sit in MAX_WINDOW cells, oldest first; every cell compares
// itself with the new sample in the same cycle, so a sample is taken every
// clock unless stalled and its result is registered. The input stalls only
// while an earlier result is itself stalled. Writing window_size empties the
// queue and restarts the sequence, as does a sample marked end of sequence.
// ----------------------------------------------------------------------------
module sliding_window_max_unit #(
    parameter int MAX_WINDOW = swm_pkg::MAX_WINDOW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  swm_pkg::t_swm_in            i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output swm_pkg::t_swm_out           o_out,
    input  logic                        i_cfg_wr_en,
    input  logic [swm_pkg::WIN_W-1:0]   i_cfg_wr_data
);

    localparam int AW = $clog2(MAX_WINDOW + 1);
    localparam int CW = (AW > swm_pkg::WIN_W) ? AW : swm_pkg::WIN_W;

    logic [swm_pkg::WIN_W-1:0] r_window_size;
    logic [AW-1:0]             r_seen, n_seen;
    logic                      r_out_valid, n_out_valid;
    swm_pkg::t_swm_out         r_out, n_out;

    logic [CW-1:0]             ws_ext;
    logic [AW-1:0]             w_eff;
    logic                      accept;
    logic                      produce;
    swm_pkg::t_cell_ctl        ctl;
    swm_pkg::t_cand            src0;

    swm_pkg::t_cand            cand [MAX_WINDOW+1];
    logic [AW-1:0]             age  [MAX_WINDOW+1];
    logic                      keep [MAX_WINDOW+1];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        ws_ext = CW'(r_window_size);
        if (ws_ext == '0) begin
            w_eff = AW'(1);
        end else if (ws_ext > CW'(MAX_WINDOW)) begin
            w_eff = AW'(MAX_WINDOW);
        end else begin
            w_eff = AW'(ws_ext);
        end
    end

    assign cand[MAX_WINDOW] = '0;
    assign age[MAX_WINDOW]  = '0;
    assign keep[0]          = 1'b1;

    always_comb begin
        ctl.step  = accept;
        ctl.clear = i_cfg_wr_en || (accept && i_in.end_of_sequence);
        ctl.drop  = cand[0].valid && (age[0] >= w_eff);
    end

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        swm_cell #(
            .AGE_W(AW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_sample   (i_in.sample),
            .i_nb_cand  (cand[g+1]),
            .i_nb_age   (age[g+1]),
            .i_prev_keep(keep[g]),
            .o_keep     (keep[g+1]),
            .o_cand     (cand[g]),
            .o_age      (age[g])
        );
    end

    always_comb begin
        src0        = ctl.drop ? cand[1] : cand[0];
        n_seen      = (r_seen < w_eff) ? r_seen + AW'(1) : w_eff;
        produce     = (n_seen >= w_eff);
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (accept) begin
            n_out_valid            = produce;
            n_out.window_max       = keep[1] ? src0.value : i_in.sample;
            n_out.last_of_sequence = i_in.end_of_sequence;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= swm_pkg::WIN_W'(1);
            r_seen        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_window_size <= i_cfg_wr_data;
                r_seen        <= '0;
            end else if (accept) begin
                r_seen <= i_in.end_of_sequence ? '0 : n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### hdl/swm_cell.sv
// ----------------------------------------------------------------------------
// Sliding window maximum: candidate cell
// One slot of the front-packed candidate queue; shifts from its neighbour on
// a front drop, keeps or takes the new sample, or empties.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int AGE_W = 7
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  swm_pkg::t_cell_ctl                 i_ctl,
    input  logic signed [swm_pkg::SAMPLE_W-1:0] i_sample,
    input  swm_pkg::t_cand                     i_nb_cand,
    input  logic [AGE_W-1:0]                   i_nb_age,
    input  logic                               i_prev_keep,
    output logic                               o_keep,
    output swm_pkg::t_cand                     o_cand,
    output logic [AGE_W-1:0]                   o_age
);

    logic                               r_valid, n_valid;
    logic signed [swm_pkg::SAMPLE_W-1:0] r_value, n_value;
    logic [AGE_W-1:0]                   r_age, n_age;
    swm_pkg::t_cand                     src;
    logic [AGE_W-1:0]                   src_age;

    always_comb begin
        src     = i_ctl.drop ? i_nb_cand
                             : swm_pkg::t_cand'{valid: r_valid, value: r_value};
        src_age = i_ctl.drop ? i_nb_age : r_age;
        o_keep  = src.valid && !(src.value < i_sample);
        n_valid = r_valid;
        n_value = r_value;
        n_age   = r_age;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.step) begin
            if (o_keep) begin
                n_valid = 1'b1;
                n_value = src.value;
                n_age   = src_age + AGE_W'(1);
            end else if (i_prev_keep) begin
                n_valid = 1'b1;
                n_value = i_sample;
                n_age   = AGE_W'(1);
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_age   <= n_age;
    end

    assign o_cand = '{valid: r_valid, value: r_value};
    assign o_age  = r_age;

endmodule

### hdl/swm_checker.sv
// ----------------------------------------------------------------------------
// Sliding window maximum: port checker
// Watches the top-level ports for handshake and result ordering slips.
// ----------------------------------------------------------------------------
`include "sliding_window_max_unit_defines.svh"

module swm_port_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input swm_pkg::t_swm_in          i_in,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input swm_pkg::t_swm_out         o_out,
    input logic                      i_cfg_wr_en,
    input logic [swm_pkg::WIN_W-1:0] i_cfg_wr_data
);

    logic in_acc;
    logic out_held;
    logic cfg_seen;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_held = o_out_valid && i_out_stall;
    assign cfg_seen = i_cfg_wr_en && (i_cfg_wr_data == i_cfg_wr_data);

    `SWM_ASSERT_NEXT(a_out_hold, out_held, o_out_valid && $stable(o_out), "stalled result changed")
    `SWM_ASSERT(a_no_spurious, $rose(o_out_valid), $past(in_acc), "result without input transaction")
    `SWM_ASSERT(a_last_echo, $past(in_acc) && o_out_valid && !cfg_seen, o_out.last_of_sequence == $past(i_in.end_of_sequence), "bad last flag")
    `SWM_ASSERT(a_stall_cause, o_in_stall, out_held, "input stalled with no stalled result")

endmodule

bind sliding_window_max_unit swm_port_checker u_swm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .i_in         (i_in),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_out        (o_out),
    .i_cfg_wr_en  (i_cfg_wr_en),
    .i_cfg_wr_data(i_cfg_wr_data)
);

### tb/swm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding window maximum: result checker
// Watches the sample, result and window length ports, keeps its own candidate
// queue to work out each window maximum, and compares every result
// transaction with the oldest one predicted.
// ----------------------------------------------------------------------------
module swm_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  swm_pkg::t_swm_in            i_in,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  swm_pkg::t_swm_out           i_out,
    input  logic                        i_cfg_wr_en,
    input  logic [swm_pkg::WIN_W-1:0]   i_cfg_wr_data,
    output int                          o_error_count,
    output int                          o_pending
);

    localparam int DEPTH = swm_pkg::MAX_WINDOW_DEF;

    logic [swm_pkg::WIN_W-1:0]           window_len;
    logic signed [swm_pkg::SAMPLE_W-1:0] cand_value [DEPTH];
    logic [swm_pkg::WIN_W-1:0]           cand_pos [DEPTH];
    int                                  cand_count;
    logic [swm_pkg::WIN_W-1:0]           position;
    int                                  seen;
    swm_pkg::t_swm_out                   max_queue [$];

    function automatic int active_window();
        if (window_len == '0) return 1;
        if (window_len > DEPTH) return DEPTH;
        return int'(window_len);
    endfunction

    function automatic logic [swm_pkg::WIN_W-1:0] age_of(
        input logic [swm_pkg::WIN_W-1:0] entry_pos);
        return position - entry_pos;
    endfunction

    task automatic clear_sequence();
        cand_count = 0;
        position   = '0;
        seen       = 0;
    endtask

    task automatic predict_window_max(input swm_pkg::t_swm_in item);
        logic signed [swm_pkg::SAMPLE_W-1:0] s;
        int                                  w;
        swm_pkg::t_swm_out                   res;
        s = item.sample;
        w = active_window();
        // expire from the front, then pop smaller ones from the back
        while (cand_count > 0 && age_of(cand_pos[0]) >= w) begin
            for (int i = 0; i < cand_count - 1; i++) begin
                cand_value[i] = cand_value[i + 1];
                cand_pos[i]   = cand_pos[i + 1];
            end
            cand_count--;
        end
        while (cand_count > 0 && cand_value[cand_count - 1] < s) begin
            cand_count--;
        end
        cand_value[cand_count] = s;
        cand_pos[cand_count]   = position;
        cand_count++;
        position++;
        if (seen < w) begin
            seen++;
        end
        if (seen >= w) begin
            res.window_max       = cand_value[0];
            res.last_of_sequence = item.end_of_sequence;
            max_queue.insert(max_queue.size(), res);
        end
        if (item.end_of_sequence) begin
            clear_sequence();
        end
    endtask

    task automatic check_result(input swm_pkg::t_swm_out got);
        swm_pkg::t_swm_out want;
        if (max_queue.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual window_max %0d last %0b",
                     $time, got.window_max, got.last_of_sequence);
            o_error_count++;
        end else begin
            want = max_queue[0];
            max_queue.delete(0);
            if (got.window_max !== want.window_max) begin
                $display("%0t: window_max mismatch, expected %0d, actual %0d",
                         $time, want.window_max, got.window_max);
                o_error_count++;
            end
            if (got.last_of_sequence !== want.last_of_sequence) begin
                $display("%0t: last_of_sequence mismatch, expected %0b, actual %0b",
                         $time, want.last_of_sequence, got.last_of_sequence);
                o_error_count++;
            end
        end
    endtask

    initial begin
        o_error_count = 0;
        o_pending     = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window_len = swm_pkg::WIN_W'(1);
            clear_sequence();
            max_queue.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_result(i_out);
            end
            if (i_cfg_wr_en) begin
                window_len = i_cfg_wr_data;
                clear_sequence();
            end
            if (i_in_valid && !i_in_stall) begin
                predict_window_max(i_in);
            end
        end
        o_pending <= max_queue.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sliding window maximum: testbench top
// Drives directed and random sample sequences over a range of window lengths,
// with random gaps and output stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int SW             = swm_pkg::SAMPLE_W;
    localparam int WW             = swm_pkg::WIN_W;

    localparam logic signed [SW-1:0] MAX_SAMPLE = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] MIN_SAMPLE = {1'b1, {(SW-1){1'b0}}};

    typedef enum int {
        PAT_RANDOM,
        PAT_CLUSTER,
        PAT_FALL,
        PAT_RISE,
        PAT_EXTREME
    } t_pattern;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    swm_pkg::t_swm_in   i_in;
    logic               o_out_valid;
    logic               i_out_stall;
    swm_pkg::t_swm_out  o_out;
    logic               i_cfg_wr_en;
    logic [WW-1:0]      i_cfg_wr_data;

    int                 error_count;
    int                 pending;
    int                 quiet_cycles;
    logic               calm;

    sliding_window_max_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in          (i_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out         (o_out),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    swm_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in          (i_in),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out         (o_out),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall = !calm && ($urandom_range(0, 99) < 6);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int span_of(input logic [WW-1:0] len);
        if (len == '0) return 1;
        if (len > swm_pkg::MAX_WINDOW_DEF) return swm_pkg::MAX_WINDOW_DEF;
        return int'(len);
    endfunction

    // called just after a falling edge; returns just after a falling edge
    task automatic send_sample(input logic signed [SW-1:0] value, input logic eos);
        while (!calm && $urandom_range(0, 99) < 6) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid             = 1'b1;
        i_in.sample            = value;
        i_in.end_of_sequence   = eos;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_window(input logic [WW-1:0] len);
        drain();
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = len;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
    endtask

    task automatic send_sequence(input int len, input t_pattern pat, input logic close);
        logic signed [SW-1:0] val;
        int                   base;
        int                   step;
        base = $urandom;
        step = $urandom_range(1, 600);
        for (int k = 0; k < len; k++) begin
            case (pat)
                PAT_CLUSTER: val = SW'(int'($urandom_range(0, 6)) - 3);
                PAT_FALL:    val = SW'(base - k * step);
                PAT_RISE:    val = SW'(base + k * step);
                PAT_EXTREME: val = $urandom_range(0, 1) ? MAX_SAMPLE : MIN_SAMPLE;
                default:     val = SW'($urandom);
            endcase
            send_sample(val, close && (k == len - 1));
        end
    endtask

    task automatic run_phase(input logic [WW-1:0] len_reg);
        int       w;
        int       budget;
        int       sent;
        int       len;
        t_pattern pat;
        write_window(len_reg);
        w      = span_of(len_reg);
        budget = (w > 30) ? w : 45;
        sent   = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 99) < 85) begin
                len = w + $urandom_range(0, 20);
            end else begin
                len = $urandom_range(1, w);
            end
            pat = t_pattern'($urandom_range(0, 4));
            // the last sequence is sometimes cut short by the next write
            send_sequence(len, pat, (sent + len < budget) || $urandom_range(0, 1));
            sent += len;
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in          = '0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        calm          = 1'b0;
        quiet_cycles  = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // window of one straight out of reset
        send_sample(MAX_SAMPLE, 1'b0);
        send_sample(MIN_SAMPLE, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b1);

        // zero length behaves as one
        write_window('0);
        send_sample(MIN_SAMPLE, 1'b1);

        // equal values kept, oldest max expires
        write_window(WW'(3));
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd7, 1'b0);
        send_sample(16'sd2, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(MIN_SAMPLE, 1'b1);

        // short sequence gives nothing
        send_sample(16'sd9, 1'b0);
        send_sample(16'sd4, 1'b1);

        run_phase(WW'(2));
        run_phase('1);
        run_phase(WW'(1));
        calm = 1'b1;
        run_phase(WW'(7));
        calm = 1'b0;
        run_phase(WW'(swm_pkg::MAX_WINDOW_DEF));
        run_phase('0);
        run_phase(WW'(swm_pkg::MAX_WINDOW_DEF + 1));
        run_phase(WW'($urandom_range(0, 127)));

        drain();
        repeat (8) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/swm_pkg.sv
hdl/swm_cell.sv
hdl/sliding_window_max_unit.sv
hdl/swm_checker.sv
tb/swm_checker.sv
tb/testbench.sv
